/* hw/rtl/bmhq_pkg.sv */
// ----------------------------------------------------------------------------
// bmhq_pkg
// Shared types and constants for the binary min-heap queue: beat layouts,
// action and status codes, and the controller/datapath command interface.
// ----------------------------------------------------------------------------
package bmhq_pkg;

  // Field widths of the request and result beats
  localparam int KEY_BITS     = 32;
  localparam int PAYLOAD_BITS = 32;
  localparam int SLOT_BITS    = 6;
  localparam int OCC_BITS     = 7;

  // Default heap depth
  localparam int CAPACITY_DEF = 64;

  // Request action codes
  typedef enum logic [1:0] {
    ACT_INSERT   = 2'd0,
    ACT_EXTRACT  = 2'd1,
    ACT_DECREASE = 2'd2
  } act_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_BAD   = 2'd3
  } status_t;

  // Request beat
  typedef struct packed {
    logic [1:0]              action;
    logic [KEY_BITS-1:0]     key_in;
    logic [PAYLOAD_BITS-1:0] payload_in;
    logic [SLOT_BITS-1:0]    slot;
  } in_beat_t;

  // Result beat
  typedef struct packed {
    logic [PAYLOAD_BITS-1:0] payload_out;
    logic [KEY_BITS-1:0]     key_out;
    status_t                 status;
    logic [OCC_BITS-1:0]     occupancy;
  } out_beat_t;

  // One heap entry
  typedef struct packed {
    logic [KEY_BITS-1:0]     key;
    logic [PAYLOAD_BITS-1:0] payload;
  } entry_t;

  // Datapath operation for the current cycle
  typedef enum logic [2:0] {
    OP_NONE,
    OP_START,
    OP_CHECK,
    OP_UP_RD,
    OP_UP_CMP,
    OP_DN_RD,
    OP_DN_CMP,
    OP_EMIT
  } dp_op_t;

  // Datapath decision fed back to the controller
  typedef struct packed {
    logic more;  // another sift step follows
    logic down;  // the sift after the check walks down
  } sts_t;

endpackage

/* hw/rtl/bmhq_dp.sv */
// ----------------------------------------------------------------------------
// bmhq_dp
// Heap datapath: entry memory with one write and two registered read ports,
// entry count, request and moving-entry registers, sift compare logic and
// the result register.
// ----------------------------------------------------------------------------
module bmhq_dp #(
  parameter int CAPACITY = bmhq_pkg::CAPACITY_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bmhq_pkg::dp_op_t    op,
  input  bmhq_pkg::in_beat_t  in_data,
  output bmhq_pkg::sts_t      sts,
  output bmhq_pkg::out_beat_t out_data
);

  localparam int AW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > bmhq_pkg::SLOT_BITS) ? CW : bmhq_pkg::SLOT_BITS;

  // Heap storage
  bmhq_pkg::entry_t mem [CAPACITY];
  bmhq_pkg::entry_t rd0_r, rd1_r;
  logic [AW-1:0]    rd0_addr, rd1_addr, wr_addr;
  logic             wr_en;
  bmhq_pkg::entry_t wr_data;

  // Control and working registers
  logic [CW-1:0]        cnt_r, cnt_nxt;
  bmhq_pkg::in_beat_t   req_r, req_nxt;
  bmhq_pkg::entry_t     item_r, item_nxt;
  logic [AW-1:0]        pos_r, pos_nxt;
  bmhq_pkg::entry_t     res_r, res_nxt;
  bmhq_pkg::status_t    res_st_r, res_st_nxt;
  bmhq_pkg::out_beat_t  out_r, out_nxt;

  // Tree neighbors of the current position
  logic [AW-1:0] parent;
  logic [CW:0]   lc_w, rc_w;
  logic          lc_ok, rc_ok;
  logic          take_l, take_r;
  logic [bmhq_pkg::KEY_BITS-1:0] best_key;
  logic          slot_bad;

  assign parent   = (pos_r - AW'(1)) >> 1;
  assign lc_w     = (CW+1)'({pos_r, 1'b1});
  assign rc_w     = lc_w + (CW+1)'(1);
  assign lc_ok    = lc_w < (CW+1)'(cnt_r);
  assign rc_ok    = rc_w < (CW+1)'(cnt_r);
  assign take_l   = rd0_r.key < item_r.key;
  assign best_key = take_l ? rd0_r.key : item_r.key;
  assign take_r   = rc_ok && (rd1_r.key < best_key);
  assign slot_bad = CMPW'(req_r.slot) >= CMPW'(cnt_r);

  // Decode the operation into next values, memory accesses and status
  always_comb begin
    cnt_nxt    = cnt_r;
    req_nxt    = req_r;
    item_nxt   = item_r;
    pos_nxt    = pos_r;
    res_nxt    = res_r;
    res_st_nxt = res_st_r;
    out_nxt    = out_r;
    wr_en      = 1'b0;
    wr_addr    = pos_r;
    wr_data    = item_r;
    rd0_addr   = '0;
    rd1_addr   = '0;
    sts        = '0;
    unique case (op)
      bmhq_pkg::OP_START: begin
        req_nxt = in_data;
        // Fetch root and last entry, or the slot to decrease
        case (in_data.action)
          bmhq_pkg::ACT_EXTRACT: begin
            rd0_addr = '0;
            rd1_addr = AW'(cnt_r - CW'(1));
          end
          bmhq_pkg::ACT_DECREASE: begin
            rd0_addr = AW'(in_data.slot);
          end
          default: ;
        endcase
      end
      bmhq_pkg::OP_CHECK: begin
        res_nxt    = '0;
        res_st_nxt = bmhq_pkg::ST_OK;
        case (req_r.action)
          bmhq_pkg::ACT_INSERT: begin
            if (cnt_r == CW'(CAPACITY)) begin
              res_st_nxt = bmhq_pkg::ST_FULL;
            end else begin
              item_nxt = {req_r.key_in, req_r.payload_in};
              pos_nxt  = AW'(cnt_r);
              cnt_nxt  = cnt_r + CW'(1);
              sts.more = 1'b1;
            end
          end
          bmhq_pkg::ACT_EXTRACT: begin
            if (cnt_r == '0) begin
              res_st_nxt = bmhq_pkg::ST_EMPTY;
            end else begin
              res_nxt  = rd0_r;
              cnt_nxt  = cnt_r - CW'(1);
              item_nxt = rd1_r;
              pos_nxt  = '0;
              sts.more = cnt_r != CW'(1);
              sts.down = 1'b1;
            end
          end
          bmhq_pkg::ACT_DECREASE: begin
            if (slot_bad || (req_r.key_in > rd0_r.key)) begin
              res_st_nxt = bmhq_pkg::ST_BAD;
            end else begin
              item_nxt = {req_r.key_in, rd0_r.payload};
              pos_nxt  = AW'(req_r.slot);
              sts.more = 1'b1;
            end
          end
          default: ;
        endcase
      end
      bmhq_pkg::OP_UP_RD: begin
        // Drop the entry at the root, else fetch the parent
        if (pos_r == '0) begin
          wr_en = 1'b1;
        end else begin
          rd0_addr = parent;
          sts.more = 1'b1;
        end
      end
      bmhq_pkg::OP_UP_CMP: begin
        // Move a larger parent down into the hole
        if (rd0_r.key > item_r.key) begin
          wr_en    = 1'b1;
          wr_data  = rd0_r;
          pos_nxt  = parent;
          sts.more = 1'b1;
        end else begin
          wr_en = 1'b1;
        end
      end
      bmhq_pkg::OP_DN_RD: begin
        // Fetch both children, or drop the entry at a leaf
        if (lc_ok) begin
          rd0_addr = AW'(lc_w);
          rd1_addr = AW'(rc_w);
          sts.more = 1'b1;
        end else begin
          wr_en = 1'b1;
        end
      end
      bmhq_pkg::OP_DN_CMP: begin
        // Pull the smaller child up; left wins a tie
        wr_en = 1'b1;
        if (take_r) begin
          wr_data  = rd1_r;
          pos_nxt  = AW'(rc_w);
          sts.more = 1'b1;
        end else if (take_l) begin
          wr_data  = rd0_r;
          pos_nxt  = AW'(lc_w);
          sts.more = 1'b1;
        end
      end
      bmhq_pkg::OP_EMIT: begin
        out_nxt.payload_out = res_r.payload;
        out_nxt.key_out     = res_r.key;
        out_nxt.status      = res_st_r;
        out_nxt.occupancy   = bmhq_pkg::OCC_BITS'(cnt_r);
      end
      default: ;
    endcase
  end

  // Memory: one write, two registered reads
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd0_r <= mem[rd0_addr];
    rd1_r <= mem[rd1_addr];
  end

  // Entry count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Working and result registers
  always_ff @(posedge clk) begin
    req_r    <= req_nxt;
    item_r   <= item_nxt;
    pos_r    <= pos_nxt;
    res_r    <= res_nxt;
    res_st_r <= res_st_nxt;
    out_r    <= out_nxt;
  end

  assign out_data = out_r;

endmodule

/* hw/rtl/bmhq_ctrl.sv */
// ----------------------------------------------------------------------------
// bmhq_ctrl
// Heap controller: sequences one request through check, sift steps and
// result hand-off, and owns both channel handshakes.
// ----------------------------------------------------------------------------
module bmhq_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  bmhq_pkg::sts_t   sts,
  output bmhq_pkg::dp_op_t op
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_UP_RD,
    S_UP_CMP,
    S_DN_RD,
    S_DN_CMP,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = state_r != S_IDLE;
  assign out_valid = out_valid_r;

  // Decode state into the datapath operation and next state
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    op            = bmhq_pkg::OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op        = bmhq_pkg::OP_START;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        op = bmhq_pkg::OP_CHECK;
        if (!sts.more) begin
          state_nxt = S_FINISH;
        end else if (sts.down) begin
          state_nxt = S_DN_RD;
        end else begin
          state_nxt = S_UP_RD;
        end
      end
      S_UP_RD: begin
        op        = bmhq_pkg::OP_UP_RD;
        state_nxt = sts.more ? S_UP_CMP : S_FINISH;
      end
      S_UP_CMP: begin
        op        = bmhq_pkg::OP_UP_CMP;
        state_nxt = sts.more ? S_UP_RD : S_FINISH;
      end
      S_DN_RD: begin
        op        = bmhq_pkg::OP_DN_RD;
        state_nxt = sts.more ? S_DN_CMP : S_FINISH;
      end
      S_DN_CMP: begin
        op        = bmhq_pkg::OP_DN_CMP;
        state_nxt = sts.more ? S_DN_RD : S_FINISH;
      end
      S_FINISH: begin
        // Hold the result until the output register is free
        if (out_free) begin
          op            = bmhq_pkg::OP_EMIT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* hw/rtl/binary_min_heap_queue.sv */
// ----------------------------------------------------------------------------
// binary_min_heap_queue
// Array-based binary min-heap of key/payload pairs with insert, extract-min
// and decrease-key requests, one result beat per request.
// ----------------------------------------------------------------------------
// The queue works on one request at a time. A request that moves nothing in
// the heap (full, empty, bad slot or larger key, unused action, or taking out
// the last entry) goes from the check straight to the result. A sift walks
// the entry level by level until it settles at the root or at a leaf, or
// stops on a compare; each sift level is one registered memory read followed
// by one compare and write. A finished result sits in an output register, so
// the next request is taken while that beat still waits under out_stall; a
// result only waits when the previous beat is still stalled.
// Keys compare unsigned; equal keys never move an entry up, and on the way
// down the left child wins a tie. Entry storage comes up undefined; no
// clearing pass is needed since only slots below the entry count are used.
module binary_min_heap_queue #(
  parameter int CAPACITY = bmhq_pkg::CAPACITY_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  bmhq_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output bmhq_pkg::out_beat_t out_data
);

  bmhq_pkg::dp_op_t dp_op;
  bmhq_pkg::sts_t   dp_sts;

  // Sequencer
  bmhq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (dp_sts),
    .op        (dp_op)
  );

  // Storage and compare logic
  bmhq_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .op       (dp_op),
    .in_data  (in_data),
    .sts      (dp_sts),
    .out_data (out_data)
  );

  // An accepted request blocks the input for the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again right after a request beat");

  // A result never overwrites a beat that is still stalled
  a_emit_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    dp_op == bmhq_pkg::OP_EMIT |-> !out_valid || !out_stall)
    else $error("result register loaded while holding a stalled beat");

  // A full report comes with a full heap
  a_full_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == bmhq_pkg::ST_FULL
      |-> out_data.occupancy == bmhq_pkg::OCC_BITS'(CAPACITY))
    else $error("full status with the heap not full");

  // An empty report comes with no entries and a zero key and payload
  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == bmhq_pkg::ST_EMPTY
      |-> out_data.occupancy == '0 && out_data.key_out == '0
          && out_data.payload_out == '0)
    else $error("empty status with nonzero fields");

endmodule

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the binary min-heap queue. A queue of requests
// (directed corner cases, then random phases that fill, drain and churn the
// heap) feeds a bursty driver; a shadow heap predicts each result beat, and
// a monitor with its own stall pattern checks every beat in order.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CAP        = bmhq_pkg::CAPACITY_DEF;
  localparam int          CYCLE_CAP  = 400000;
  localparam int          TAIL_WAIT  = 40;
  localparam int          PRINT_CAP  = 200;
  localparam logic [1:0]  ACT_UNUSED = 2'd3;

  // One queued request, optionally held until the heap has answered all
  typedef struct {
    bmhq_pkg::in_beat_t beat;
    bit                 drain;
  } heap_req_t;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  bmhq_pkg::in_beat_t  in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  bmhq_pkg::out_beat_t out_data;

  heap_req_t           pending_reqs[$];
  bmhq_pkg::out_beat_t owed_answers[$];
  int                  mismatches = 0;
  int                  cycles     = 0;
  int                  gen_count  = 0;
  int                  burst_left = 0;
  int                  gap_left   = 0;

  // Shadow heap
  logic [bmhq_pkg::KEY_BITS-1:0]     pq_key[CAP];
  logic [bmhq_pkg::PAYLOAD_BITS-1:0] pq_pay[CAP];
  int                                pq_count = 0;

  binary_min_heap_queue u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void pq_swap(int a, int b);
    logic [bmhq_pkg::KEY_BITS-1:0]     tk;
    logic [bmhq_pkg::PAYLOAD_BITS-1:0] tp;
    tk = pq_key[a];
    tp = pq_pay[a];
    pq_key[a] = pq_key[b];
    pq_pay[a] = pq_pay[b];
    pq_key[b] = tk;
    pq_pay[b] = tp;
  endfunction

  // Move an entry toward the root while its parent is strictly larger
  function automatic void pq_rise(int pos);
    int up;
    while (pos > 0) begin
      up = (pos - 1) / 2;
      if (pq_key[up] <= pq_key[pos]) break;
      pq_swap(pos, up);
      pos = up;
    end
  endfunction

  // Move an entry toward the leaves; the left child wins a tie
  function automatic void pq_sink(int pos);
    int lc;
    int rc;
    int best;
    while (pos < pq_count) begin
      lc = 2 * pos + 1;
      rc = 2 * pos + 2;
      best = pos;
      if (lc < pq_count && pq_key[lc] < pq_key[best]) best = lc;
      if (rc < pq_count && pq_key[rc] < pq_key[best]) best = rc;
      if (best == pos) break;
      pq_swap(pos, best);
      pos = best;
    end
  endfunction

  // Apply one request to the shadow heap and return the beat it answers with
  function automatic bmhq_pkg::out_beat_t serve_request(bmhq_pkg::in_beat_t req);
    bmhq_pkg::out_beat_t ans;
    ans = '0;
    ans.status = bmhq_pkg::ST_OK;
    case (req.action)
      bmhq_pkg::ACT_INSERT: begin
        if (pq_count >= CAP) begin
          ans.status = bmhq_pkg::ST_FULL;
        end else begin
          pq_key[pq_count] = req.key_in;
          pq_pay[pq_count] = req.payload_in;
          pq_count++;
          pq_rise(pq_count - 1);
        end
      end
      bmhq_pkg::ACT_EXTRACT: begin
        if (pq_count == 0) begin
          ans.status = bmhq_pkg::ST_EMPTY;
        end else begin
          ans.key_out     = pq_key[0];
          ans.payload_out = pq_pay[0];
          pq_count--;
          if (pq_count > 0) begin
            pq_key[0] = pq_key[pq_count];
            pq_pay[0] = pq_pay[pq_count];
            pq_sink(0);
          end
        end
      end
      bmhq_pkg::ACT_DECREASE: begin
        if (int'(req.slot) >= pq_count || req.key_in > pq_key[req.slot]) begin
          ans.status = bmhq_pkg::ST_BAD;
        end else begin
          pq_key[req.slot] = req.key_in;
          pq_rise(int'(req.slot));
        end
      end
      default: begin
      end
    endcase
    ans.occupancy = bmhq_pkg::OCC_BITS'(pq_count);
    return ans;
  endfunction

  // Print one line per bad beat, up to a cap, and count every one
  task automatic report_mismatch(string what);
    if (mismatches < PRINT_CAP) $display("MISMATCH @%0d: %s", cycles, what);
    mismatches++;
  endtask

  // Queue a request; track the entry count so decreases can aim at live slots
  task automatic add_req(logic [1:0] act, logic [bmhq_pkg::KEY_BITS-1:0] key,
                         logic [bmhq_pkg::PAYLOAD_BITS-1:0] pay,
                         logic [bmhq_pkg::SLOT_BITS-1:0] slot, bit drain);
    heap_req_t r;
    r.beat.action     = act;
    r.beat.key_in     = key;
    r.beat.payload_in = pay;
    r.beat.slot       = slot;
    r.drain           = drain;
    pending_reqs.insert(pending_reqs.size(), r);
    if (act == bmhq_pkg::ACT_INSERT && gen_count < CAP) gen_count++;
    if (act == bmhq_pkg::ACT_EXTRACT && gen_count > 0) gen_count--;
  endtask

  // Driver: bursts with random gaps; hold a drain-marked beat until all answered
  always @(posedge clk) begin : drive
    heap_req_t nxt;
    if (!rst_n) begin
      in_valid   <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        owed_answers.insert(owed_answers.size(), serve_request(in_data));
      end
      if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_reqs.size() != 0 &&
                   !(pending_reqs[0].drain && owed_answers.size() != 0)) begin
        nxt = pending_reqs.pop_front();
        in_valid <= 1'b1;
        in_data  <= nxt.beat;
        if (burst_left > 1) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(1, 24);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: check each result beat, then pick the next stall value
  int stall_mode = 0;
  int mode_left  = 0;
  int stall_tick = 0;

  always @(posedge clk) begin : observe
    bmhq_pkg::out_beat_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (owed_answers.size() == 0) begin
          report_mismatch($sformatf("unexpected beat %h", out_data));
        end else begin
          want = owed_answers.pop_front();
          if (out_data.payload_out !== want.payload_out ||
              out_data.key_out !== want.key_out ||
              out_data.status !== want.status ||
              out_data.occupancy !== want.occupancy) begin
            report_mismatch($sformatf(
              "got pay=%h key=%h st=%0d occ=%0d, want pay=%h key=%h st=%0d occ=%0d",
              out_data.payload_out, out_data.key_out, out_data.status,
              out_data.occupancy, want.payload_out, want.key_out, want.status,
              want.occupancy));
          end
        end
      end
      // switch stall pattern now and then: none, light, heavy, periodic
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(32, 256);
      end
      mode_left--;
      stall_tick++;
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 9) < 3);
        2:       out_stall <= ($urandom_range(0, 9) < 8);
        default: out_stall <= ((stall_tick % 8) < 3);
      endcase
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_CAP) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin
    int                                pct_ins;
    int                                pct_ext;
    int                                r;
    bit                                narrow;
    logic [1:0]                        act;
    logic [bmhq_pkg::KEY_BITS-1:0]     key;
    logic [bmhq_pkg::SLOT_BITS-1:0]    slot;

    // Directed: empty heap, unused action, key extremes, ties, decrease cases
    add_req(bmhq_pkg::ACT_EXTRACT, '0, '0, '0, 1'b0);
    add_req(bmhq_pkg::ACT_DECREASE, '0, '0, '0, 1'b0);
    add_req(bmhq_pkg::ACT_DECREASE, '1, '1, '1, 1'b0);
    add_req(ACT_UNUSED, '1, '1, '1, 1'b0);
    add_req(bmhq_pkg::ACT_INSERT, '1, '1, '1, 1'b0);
    add_req(bmhq_pkg::ACT_INSERT, '0, '0, '0, 1'b0);
    add_req(bmhq_pkg::ACT_INSERT, 32'd5, 32'h0000_000a, 6'd1, 1'b0);
    add_req(bmhq_pkg::ACT_INSERT, 32'd5, 32'h0000_000b, 6'd2, 1'b0);
    add_req(bmhq_pkg::ACT_DECREASE, '1, '0, 6'd3, 1'b0);     // equal key is accepted
    add_req(bmhq_pkg::ACT_DECREASE, 32'd6, '0, 6'd2, 1'b0);  // larger key is refused
    add_req(bmhq_pkg::ACT_DECREASE, '0, '0, 6'd4, 1'b0);     // slot at the entry count
    add_req(bmhq_pkg::ACT_DECREASE, 32'd1, '0, 6'd3, 1'b0);  // climbs one level
    add_req(bmhq_pkg::ACT_DECREASE, '0, '0, 6'd0, 1'b0);
    add_req(bmhq_pkg::ACT_INSERT, 32'd5, 32'h0000_000c, 6'd0, 1'b0);
    add_req(ACT_UNUSED, '0, '0, '0, 1'b0);
    repeat (6) add_req(bmhq_pkg::ACT_EXTRACT, 32'h1234_5678, 32'h9abc_def0, 6'd5, 1'b0);

    // Random phases: fill, drain, mixed, mixed with clashing keys
    for (int ph = 0; ph < 7; ph++) begin
      case (ph % 4)
        0:       begin pct_ins = 80; pct_ext = 8;  end
        1:       begin pct_ins = 12; pct_ext = 72; end
        default: begin pct_ins = 45; pct_ext = 35; end
      endcase
      narrow = (ph % 4 == 3);
      for (int n = 0; n < 100; n++) begin
        r = $urandom_range(0, 99);
        if (r < pct_ins) act = bmhq_pkg::ACT_INSERT;
        else if (r < pct_ins + pct_ext) act = bmhq_pkg::ACT_EXTRACT;
        else if (r < 98) act = bmhq_pkg::ACT_DECREASE;
        else act = ACT_UNUSED;
        r = $urandom_range(0, 9);
        if (act == bmhq_pkg::ACT_DECREASE) begin
          if (r < 4) key = $urandom_range(0, 255);
          else if (r < 7) key = $urandom_range(0, 7);
          else key = $urandom;
          if (gen_count > 0 && $urandom_range(0, 9) != 0) begin
            slot = bmhq_pkg::SLOT_BITS'($urandom_range(0, gen_count - 1));
          end else begin
            slot = bmhq_pkg::SLOT_BITS'($urandom_range(0, 63));
          end
        end else begin
          if (narrow || r < 2) key = $urandom_range(0, 7);
          else if (r == 2) key = '0;
          else if (r == 3) key = '1;
          else key = $urandom;
          slot = bmhq_pkg::SLOT_BITS'($urandom_range(0, 63));
        end
        add_req(act, key, $urandom, slot, n == 0);
      end
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every beat to go in and every answer to come out, then linger
    while (pending_reqs.size() != 0 || in_valid || owed_answers.size() != 0)
      @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);

    if (mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
